### design/pmc_pkg.sv
// Shared types and constants of the pointing model correction block.
// Used by every module of the block except pmc_delay; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TERM1 = 3'd0;
  localparam logic [2:0] REG_TERM2 = 3'd1;
  localparam logic [2:0] REG_TERM3 = 3'd2;
  localparam logic [2:0] REG_TERM4 = 3'd3;
  localparam logic [2:0] REG_TERM5 = 3'd4;

  // angle to phase: about 2^61/pi, split in two words
  localparam logic [27:0] PHASE_MUL_HI = 28'hA2F9836;
  localparam logic [31:0] PHASE_MUL_LO = 32'hE4E44153;
  localparam logic [31:0] PHASE_0P2    = 32'd136713055;
  localparam logic [31:0] PHASE_0P35   = 32'd239247846;

  localparam logic [30:0] ONE30       = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [50:0] RAD_PER_ARCMIN = 51'(HALF_PI_Q62 / 64'd5400);

  localparam logic [56:0] WORK_LIM = 57'(64'd1 << 56);
  localparam logic [36:0] MM_LIM   = 37'((64'd1 << 56) / 64'd1000000);
  localparam logic [19:0] MILLION  = 20'd1000000;

  // Taylor divisors of the Horner steps
  localparam int SIN_DIV [5] = '{110, 72, 42, 20, 6};
  localparam int COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

  localparam int QBITS     = 57;         // quotient bits of the divider
  localparam int DIV_LAT   = QBITS + 2;  // prepare + one step per bit + finish
  localparam int SC_LAT    = 21;         // phase in to sin/cos out
  localparam int TORAD_LAT = 4;

  typedef struct packed {
    logic [30:0]      rem;
    logic [30:0]      dvs;
    logic [QBITS-1:0] num;
    logic [QBITS-1:0] quo;
  } pmc_div_work_t;

  typedef struct packed {
    logic neg;
    logic nneg;
    logic zden;
    logic nz;
    logic ovf;
  } pmc_div_flag_t;

endpackage

`default_nettype wire

### design/pmc_delay.sv
// Fixed-length register delay line for pipeline side data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pmc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    pipe_r[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[DEPTH-1];

endmodule

`default_nettype wire

### design/pmc_horner_cell.sv
// One Horner step acc' = 1 - ((x2*acc) >> 30) / DIV in Q30, three stages.
// Uses pmc_pkg constants.
`timescale 1ns / 1ps
`default_nettype none

module pmc_horner_cell #(
  parameter int DIV = 6
) (
  input  wire logic        clk,
  input  wire logic [29:0] x2_i,
  input  wire logic [30:0] acc_i,
  output logic      [29:0] x2_o,
  output logic      [30:0] acc_o
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

  logic [60:0] prod;
  logic [29:0] v_a_r, x2_a_r;
  logic [61:0] qe;
  logic [29:0] q0_b_r, v_b_r, x2_b_r;
  logic [37:0] qd;
  logic [30:0] rem;
  logic [29:0] qf;
  logic [30:0] acc_c_r;
  logic [29:0] x2_c_r;

  assign prod = 61'(x2_i) * 61'(acc_i);

  always_ff @(posedge clk) begin
    v_a_r  <= prod[59:30];
    x2_a_r <= x2_i;
  end

  // reciprocal estimate, low by at most one
  assign qe = 62'(v_a_r) * 62'(RECIP);

  always_ff @(posedge clk) begin
    q0_b_r <= qe[61:32];
    v_b_r  <= v_a_r;
    x2_b_r <= x2_a_r;
  end

  assign qd  = 38'(q0_b_r) * 38'(DIV);
  assign rem = {1'b0, v_b_r} - qd[30:0];
  assign qf  = (rem >= 31'(DIV)) ? q0_b_r + 30'd1 : q0_b_r;

  always_ff @(posedge clk) begin
    acc_c_r <= pmc_pkg::ONE30 - {1'b0, qf};
    x2_c_r  <= x2_b_r;
  end

  assign x2_o  = x2_c_r;
  assign acc_o = acc_c_r;

endmodule

`default_nettype wire

### design/pmc_sincos.sv
// Pipelined sine and cosine of a 32-bit phase: octant fold, Horner chains.
// Uses pmc_pkg, pmc_delay and pmc_horner_cell.
`timescale 1ns / 1ps
`default_nettype none

module pmc_sincos (
  input  wire logic        clk,
  input  wire logic [31:0] phase,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic [29:0] r;
  logic        swap;
  logic [29:0] rr;
  logic [60:0] xp;
  logic [29:0] x1_r, x1d_r, x2_r;
  logic [1:0]  q1_r, q2_r;
  logic        swap1_r, swap2_r;
  logic [59:0] xx;

  assign r    = phase[29:0];
  assign swap = r > 30'h2000_0000;
  assign rr   = swap ? 30'(pmc_pkg::ONE30 - {1'b0, r}) : r;
  assign xp   = 61'(rr) * 61'(pmc_pkg::HALF_PI_Q30);

  always_ff @(posedge clk) begin
    x1_r    <= xp[59:30];
    q1_r    <= phase[31:30];
    swap1_r <= swap;
  end

  assign xx = 60'(x1_r) * 60'(x1_r);

  always_ff @(posedge clk) begin
    x2_r    <= xx[59:30];
    x1d_r   <= x1_r;
    q2_r    <= q1_r;
    swap2_r <= swap1_r;
  end

  logic [29:0] sin_x2  [6];
  logic [30:0] sin_acc [6];
  logic [29:0] cos_x2  [7];
  logic [30:0] cos_acc [7];

  assign sin_x2[0]  = x2_r;
  assign sin_acc[0] = pmc_pkg::ONE30;
  assign cos_x2[0]  = x2_r;
  assign cos_acc[0] = pmc_pkg::ONE30;

  for (genvar g = 0; g < 5; g++) begin : g_sin
    pmc_horner_cell #(.DIV(pmc_pkg::SIN_DIV[g])) u_step (
      .clk   (clk),
      .x2_i  (sin_x2[g]),
      .acc_i (sin_acc[g]),
      .x2_o  (sin_x2[g+1]),
      .acc_o (sin_acc[g+1])
    );
  end

  for (genvar g = 0; g < 6; g++) begin : g_cos
    pmc_horner_cell #(.DIV(pmc_pkg::COS_DIV[g])) u_step (
      .clk   (clk),
      .x2_i  (cos_x2[g]),
      .acc_i (cos_acc[g]),
      .x2_o  (cos_x2[g+1]),
      .acc_o (cos_acc[g+1])
    );
  end

  logic [29:0] x_d;
  logic [60:0] sp;
  logic [30:0] sv_r, sv_d;
  logic [2:0]  qs_d;

  pmc_delay #(.WIDTH(30), .DEPTH(15)) u_xdly (.clk(clk), .d(x1d_r), .q(x_d));

  assign sp = 61'(x_d) * 61'(sin_acc[5]);

  always_ff @(posedge clk) begin
    sv_r <= sp[60:30];
  end

  // align the shorter sine chain with the cosine chain
  pmc_delay #(.WIDTH(31), .DEPTH(2)) u_sdly (.clk(clk), .d(sv_r), .q(sv_d));
  pmc_delay #(.WIDTH(3), .DEPTH(18)) u_qdly (
    .clk (clk),
    .d   ({q2_r, swap2_r}),
    .q   (qs_d)
  );

  logic signed [31:0] sa, ca, s_nxt, c_nxt;
  logic signed [31:0] sin_r, cos_r;

  always_comb begin
    sa = qs_d[0] ? $signed({1'b0, cos_acc[6]}) : $signed({1'b0, sv_d});
    ca = qs_d[0] ? $signed({1'b0, sv_d}) : $signed({1'b0, cos_acc[6]});
    case (qs_d[2:1])
      2'd0: begin
        s_nxt = sa;
        c_nxt = ca;
      end
      2'd1: begin
        s_nxt = ca;
        c_nxt = -sa;
      end
      2'd2: begin
        s_nxt = -sa;
        c_nxt = -ca;
      end
      default: begin
        s_nxt = -ca;
        c_nxt = sa;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_r <= s_nxt;
    cos_r <= c_nxt;
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

`default_nettype wire

### design/pmc_div_cell.sv
// One restoring division step: shift in a dividend bit, compare, subtract.
// Uses pmc_pkg work type.
`timescale 1ns / 1ps
`default_nettype none

module pmc_div_cell (
  input  wire logic                   clk,
  input  wire pmc_pkg::pmc_div_work_t work_i,
  output pmc_pkg::pmc_div_work_t      work_o
);

  logic [31:0] t;
  logic        ge;
  pmc_pkg::pmc_div_work_t work_nxt, work_r;

  assign t  = {work_i.rem, work_i.num[pmc_pkg::QBITS-1]};
  assign ge = t >= {1'b0, work_i.dvs};

  always_comb begin
    work_nxt     = work_i;
    work_nxt.rem = ge ? 31'(t - {1'b0, work_i.dvs}) : t[30:0];
    work_nxt.num = {work_i.num[pmc_pkg::QBITS-2:0], 1'b0};
    work_nxt.quo = {work_i.quo[pmc_pkg::QBITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign work_o = work_r;

endmodule

`default_nettype wire

### design/pmc_divider.sv
// Pipelined num * 2^SHIFT / den, truncated toward zero, clamped to +-2^56.
// Uses pmc_pkg, pmc_delay and a row of pmc_div_cell steps.
`timescale 1ns / 1ps
`default_nettype none

module pmc_divider #(
  parameter int SHIFT = 8
) (
  input  wire logic               clk,
  input  wire logic signed [63:0] num,
  input  wire logic signed [31:0] den,
  output logic signed      [57:0] res
);

  localparam int QB    = pmc_pkg::QBITS;
  localparam int NW    = 64 + SHIFT;
  localparam int TOP_W = NW - QB;
  localparam int CMP_W = (TOP_W > 31) ? TOP_W : 31;

  logic [63:0]      nmag;
  logic [31:0]      dmag;
  logic [NW-1:0]    nsh;
  logic [TOP_W-1:0] top;
  pmc_pkg::pmc_div_flag_t flag, flag_d;
  pmc_pkg::pmc_div_work_t work0_r;
  pmc_pkg::pmc_div_work_t work [QB+1];

  assign nmag = num[63] ? 64'(-num) : 64'(num);
  assign dmag = den[31] ? 32'(-den) : 32'(den);
  assign nsh  = {nmag, {SHIFT{1'b0}}};
  assign top  = nsh[NW-1:QB];

  always_comb begin
    flag.neg  = num[63] ^ den[31];
    flag.nneg = num[63];
    flag.zden = den == 32'sd0;
    flag.nz   = num != 64'sd0;
    // quotient would need more than QB bits
    flag.ovf  = CMP_W'(top) >= CMP_W'(dmag[30:0]);
  end

  always_ff @(posedge clk) begin
    work0_r.rem <= 31'(top);
    work0_r.dvs <= dmag[30:0];
    work0_r.num <= nsh[QB-1:0];
    work0_r.quo <= '0;
  end

  pmc_delay #(.WIDTH($bits(pmc_pkg::pmc_div_flag_t)), .DEPTH(QB + 1)) u_fdly (
    .clk (clk),
    .d   (flag),
    .q   (flag_d)
  );

  assign work[0] = work0_r;

  for (genvar g = 0; g < QB; g++) begin : g_step
    pmc_div_cell u_step (
      .clk    (clk),
      .work_i (work[g]),
      .work_o (work[g+1])
    );
  end

  logic [QB-1:0]      mag;
  logic               sgn;
  logic signed [57:0] res_r;

  always_comb begin
    if (flag_d.zden) begin
      mag = flag_d.nz ? pmc_pkg::WORK_LIM : '0;
      sgn = flag_d.nneg;
    end else begin
      mag = (flag_d.ovf || work[QB].quo > pmc_pkg::WORK_LIM) ?
            pmc_pkg::WORK_LIM : work[QB].quo;
      sgn = flag_d.neg;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= sgn ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign res = res_r;

endmodule

`default_nettype wire

### design/pmc_to_rad.sv
// Arcminutes (working units) to radians: magnitude times pi/10800 in Q62,
// split in 32-bit partial products, shifted right by SHIFT. Uses pmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmc_to_rad #(
  parameter int SHIFT = 58
) (
  input  wire logic               clk,
  input  wire logic signed [59:0] val,
  output logic signed      [63:0] rad
);

  localparam int PW = 111;

  logic [59:0] mag_r;
  logic        neg1_r, neg2_r, neg3_r, neg4_r;
  logic [63:0] p00_r, p10_r;
  logic [50:0] p01_r;
  logic [46:0] p11_r;
  logic [PW-1:0] sa_r, sb_r, full;
  logic [63:0] m;
  logic signed [63:0] rad_r;

  always_ff @(posedge clk) begin
    mag_r  <= val[59] ? 60'(-val) : 60'(val);
    neg1_r <= val[59];
  end

  always_ff @(posedge clk) begin
    p00_r  <= 64'(mag_r[31:0]) * 64'(pmc_pkg::RAD_PER_ARCMIN[31:0]);
    p01_r  <= 51'(mag_r[31:0]) * 51'(pmc_pkg::RAD_PER_ARCMIN[50:32]);
    p10_r  <= 64'(mag_r[59:32]) * 64'(pmc_pkg::RAD_PER_ARCMIN[31:0]);
    p11_r  <= 47'(mag_r[59:32]) * 47'(pmc_pkg::RAD_PER_ARCMIN[50:32]);
    neg2_r <= neg1_r;
  end

  always_ff @(posedge clk) begin
    sa_r   <= PW'(p00_r) + (PW'(p01_r) << 32);
    sb_r   <= (PW'(p10_r) << 32) + (PW'(p11_r) << 64);
    neg3_r <= neg2_r;
  end

  assign full = sa_r + sb_r;
  assign m    = 64'(full >> SHIFT);

  always_ff @(posedge clk) begin
    rad_r  <= neg3_r ? -$signed(m) : $signed(m);
    neg4_r <= neg3_r;
  end

  assign rad = (neg4_r && rad_r > 64'sd0) ? -rad_r : rad_r;

endmodule

`default_nettype wire

### design/pointing_model_correction.sv
// Ten-term mount pointing correction: a free-running pipeline that takes one
// request in every cycle (busy stays low) and delivers each result on out_valid
// for one cycle; the receiver cannot stall, and results leave in request order.
// The latency is set by two chained 57-step dividers (tan(dec) and the division
// by cos(dec)) plus the Horner chains of the sine/cosine units. Configuration
// must be written only while no request is in flight; the block itself does not
// enforce this. Depends on pmc_pkg, pmc_sincos, pmc_divider, pmc_to_rad, pmc_delay.
`timescale 1ns / 1ps
`default_nettype none

module pointing_model_correction #(
  parameter int ANGLE_FRAC_BITS = 28,
  parameter int COEF_FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_hour_angle,
  input  wire logic signed [31:0] in_declination,
  input  wire logic signed [31:0] in_ha_error_in,
  input  wire logic signed [31:0] in_dec_error_in,
  output logic                    out_valid,
  output logic signed      [31:0] out_ha_error_out,
  output logic signed      [31:0] out_dec_error_out
);

  localparam int PHASE_SHIFT = ANGLE_FRAC_BITS - 2;
  localparam int RAD_SHIFT   = 70 + COEF_FRAC_BITS - ANGLE_FRAC_BITS;
  localparam logic [31:0] POLE_LIM =
    32'(pmc_pkg::HALF_PI_Q62 >> (62 - ANGLE_FRAC_BITS));

  // pipeline levels (the register level at which each step holds the request)
  localparam int L_PH4   = 4;
  localparam int L_TRIG  = L_PH4 + pmc_pkg::SC_LAT;
  localparam int L_PROD  = L_TRIG + 1;
  localparam int L_DPART = L_PROD + 1;
  localparam int L_HPART = L_PROD + 3;
  localparam int L_DIV1  = L_PROD + pmc_pkg::DIV_LAT;
  localparam int L_SUM   = L_DIV1 + 1;
  localparam int L_MM    = L_SUM + 2;
  localparam int L_DIV3  = L_SUM + pmc_pkg::DIV_LAT;
  localparam int L_MOD   = L_DIV3 + 1;
  localparam int L_RAD   = L_MOD + pmc_pkg::TORAD_LAT;
  localparam int L_OUT   = L_RAD + 1;

  // ---------------- configuration ----------------
  logic [63:0] term_r [5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        term_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        pmc_pkg::REG_TERM1: term_r[0] <= cfg_wdata;
        pmc_pkg::REG_TERM2: term_r[1] <= cfg_wdata;
        pmc_pkg::REG_TERM3: term_r[2] <= cfg_wdata;
        pmc_pkg::REG_TERM4: term_r[3] <= cfg_wdata;
        pmc_pkg::REG_TERM5: term_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [31:0] a1, a2, a3, a4, a5, b1, b2, b3, b4, b5;
  assign a1 = $signed(term_r[0][63:32]);
  assign b1 = $signed(term_r[0][31:0]);
  assign a2 = $signed(term_r[1][63:32]);
  assign b2 = $signed(term_r[1][31:0]);
  assign a3 = $signed(term_r[2][63:32]);
  assign b3 = $signed(term_r[2][31:0]);
  assign a4 = $signed(term_r[3][63:32]);
  assign b4 = $signed(term_r[3][31:0]);
  assign a5 = $signed(term_r[4][63:32]);
  assign b5 = $signed(term_r[4][31:0]);

  // ---------------- request valid ----------------
  logic             accept;
  logic [L_OUT-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[L_OUT-2:0], accept};
    end
  end

  // ---------------- angles to phases ----------------
  logic signed [31:0] ha_r, dec_r, eha_r, edec_r;
  logic [31:0] hmag, dmag;
  logic [63:0] mlo_h_r, mhi_h_r, mlo_d_r, mhi_d_r;
  logic        neg_h_r, neg_d_r, pole_r;
  logic [63:0] th, td;
  logic [31:0] p_h, p_d;
  logic [31:0] ph_r, pd_r, ph4_r, pd4_r, ph2_r, pd35_r;

  always_ff @(posedge clk) begin
    ha_r   <= in_hour_angle;
    dec_r  <= in_declination;
    eha_r  <= in_ha_error_in;
    edec_r <= in_dec_error_in;
  end

  assign hmag = ha_r[31] ? 32'(-ha_r) : 32'(ha_r);
  assign dmag = dec_r[31] ? 32'(-dec_r) : 32'(dec_r);

  always_ff @(posedge clk) begin
    mlo_h_r <= 64'(hmag) * 64'(pmc_pkg::PHASE_MUL_LO);
    mhi_h_r <= 64'(hmag) * 64'(pmc_pkg::PHASE_MUL_HI);
    mlo_d_r <= 64'(dmag) * 64'(pmc_pkg::PHASE_MUL_LO);
    mhi_d_r <= 64'(dmag) * 64'(pmc_pkg::PHASE_MUL_HI);
    neg_h_r <= ha_r[31];
    neg_d_r <= dec_r[31];
    pole_r  <= dmag <= POLE_LIM;
  end

  assign th  = mhi_h_r + {32'd0, mlo_h_r[63:32]};
  assign td  = mhi_d_r + {32'd0, mlo_d_r[63:32]};
  assign p_h = th[PHASE_SHIFT +: 32];
  assign p_d = td[PHASE_SHIFT +: 32];

  always_ff @(posedge clk) begin
    ph_r <= neg_h_r ? -p_h : p_h;
    pd_r <= neg_d_r ? -p_d : p_d;
  end

  always_ff @(posedge clk) begin
    ph4_r  <= ph_r;
    pd4_r  <= pd_r;
    ph2_r  <= ph_r - pmc_pkg::PHASE_0P2;
    pd35_r <= pd_r + pmc_pkg::PHASE_0P35;
  end

  // ---------------- trig ----------------
  logic signed [31:0] sh, ch, sd, cd, ch2, cd35;

  pmc_sincos u_sc_h (.clk(clk), .phase(ph4_r), .sin_o(sh), .cos_o(ch));
  pmc_sincos u_sc_d (.clk(clk), .phase(pd4_r), .sin_o(sd), .cos_o(cd));
  pmc_sincos u_sc_h2 (.clk(clk), .phase(ph2_r), .sin_o(), .cos_o(ch2));
  pmc_sincos u_sc_d35 (.clk(clk), .phase(pd35_r), .sin_o(), .cos_o(cd35));

  // ---------------- model terms ----------------
  logic signed [63:0] p_a1sh_r, p_a2ch_r, p_a4ch2_r, p_a5sd_r;
  logic signed [63:0] p_b1ch_r, p_b2sh_r, p_b4cd_r, p_b5sd_r;
  logic signed [23:0] sd8_r, sd8_27_r;
  logic signed [31:0] cd26_r;

  always_ff @(posedge clk) begin
    p_a1sh_r  <= a1 * sh;
    p_a2ch_r  <= a2 * ch;
    p_a4ch2_r <= a4 * ch2;
    p_a5sd_r  <= a5 * sd;
    p_b1ch_r  <= b1 * ch;
    p_b2sh_r  <= b2 * sh;
    p_b4cd_r  <= b4 * cd35;
    p_b5sd_r  <= b5 * sd;
    sd8_r     <= 24'(sd >>> 8);
    cd26_r    <= cd;
  end

  logic signed [41:0] pol_r;
  logic signed [63:0] ht4_r, ht4_28_r, dpart_r, polsd_r, hpart_r;

  always_ff @(posedge clk) begin
    pol_r    <= 42'((p_a1sh_r - p_a2ch_r) >>> 22);
    ht4_r    <= p_a4ch2_r >>> 22;
    dpart_r  <= (p_b1ch_r >>> 22) + (p_b2sh_r >>> 22) + (64'(b3) <<< 8)
              + (p_b4cd_r >>> 22);
    sd8_27_r <= sd8_r;
  end

  always_ff @(posedge clk) begin
    polsd_r  <= pol_r * sd8_27_r;
    ht4_28_r <= ht4_r;
  end

  always_ff @(posedge clk) begin
    hpart_r <= (polsd_r >>> 22) + (64'(a3) <<< 8) + ht4_28_r;
  end

  // tan(dec) terms
  logic signed [57:0] div_a5, div_b5;

  pmc_divider #(.SHIFT(8)) u_div_a5 (.clk(clk), .num(p_a5sd_r), .den(cd26_r), .res(div_a5));
  pmc_divider #(.SHIFT(8)) u_div_b5 (.clk(clk), .num(p_b5sd_r), .den(cd26_r), .res(div_b5));

  logic signed [63:0] hpart_d, dpart_d;

  pmc_delay #(.WIDTH(64), .DEPTH(L_DIV1 - L_HPART)) u_hpdly (
    .clk (clk),
    .d   (hpart_r),
    .q   (hpart_d)
  );
  pmc_delay #(.WIDTH(64), .DEPTH(L_DIV1 - L_DPART)) u_dpdly (
    .clk (clk),
    .d   (dpart_r),
    .q   (dpart_d)
  );

  logic signed [63:0] hsum_r, dsum_r;

  always_ff @(posedge clk) begin
    hsum_r <= hpart_d + 64'(div_a5);
    dsum_r <= dpart_d + 64'(div_b5);
  end

  // ---------------- division by cos(dec), or times 1e6 past the pole ----------------
  logic signed [31:0] cd_d;
  logic signed [57:0] div_h;

  pmc_delay #(.WIDTH(32), .DEPTH(L_SUM - L_TRIG)) u_cddly (.clk(clk), .d(cd), .q(cd_d));

  pmc_divider #(.SHIFT(30)) u_div_h (.clk(clk), .num(hsum_r), .den(cd_d), .res(div_h));

  logic [63:0]        mmag_r;
  logic               mbig_r, mneg_r;
  logic [56:0]        mm;
  logic signed [57:0] mm_r, mm_d;

  always_ff @(posedge clk) begin
    mmag_r <= hsum_r[63] ? 64'(-hsum_r) : 64'(hsum_r);
    mbig_r <= (hsum_r[63] ? 64'(-hsum_r) : 64'(hsum_r)) > 64'(pmc_pkg::MM_LIM);
    mneg_r <= hsum_r[63];
  end

  assign mm = mbig_r ? pmc_pkg::WORK_LIM : 57'(mmag_r[36:0]) * 57'(pmc_pkg::MILLION);

  always_ff @(posedge clk) begin
    mm_r <= mneg_r ? -$signed({1'b0, mm}) : $signed({1'b0, mm});
  end

  pmc_delay #(.WIDTH(58), .DEPTH(L_DIV3 - L_MM)) u_mmdly (.clk(clk), .d(mm_r), .q(mm_d));

  logic pole_d;
  pmc_delay #(.WIDTH(1), .DEPTH(L_DIV3 - 2)) u_pldly (.clk(clk), .d(pole_r), .q(pole_d));

  logic signed [63:0] dsum_d;
  pmc_delay #(.WIDTH(64), .DEPTH(L_MOD - L_SUM)) u_dsdly (.clk(clk), .d(dsum_r), .q(dsum_d));

  logic signed [57:0] hmod_r;

  always_ff @(posedge clk) begin
    hmod_r <= pole_d ? div_h : mm_d;
  end

  // ---------------- to radians and accumulate ----------------
  logic signed [63:0] rad_h, rad_d;

  pmc_to_rad #(.SHIFT(RAD_SHIFT)) u_rad_h (.clk(clk), .val(60'(hmod_r)), .rad(rad_h));
  pmc_to_rad #(.SHIFT(RAD_SHIFT)) u_rad_d (.clk(clk), .val(60'(dsum_d)), .rad(rad_d));

  logic signed [31:0] eha_d, edec_d;

  pmc_delay #(.WIDTH(64), .DEPTH(L_RAD - 1)) u_erdly (
    .clk (clk),
    .d   ({eha_r, edec_r}),
    .q   ({eha_d, edec_d})
  );

  logic signed [63:0] sum_h, sum_d;
  logic signed [31:0] out_h_r, out_d_r;

  assign sum_h = 64'(eha_d) + rad_h;
  assign sum_d = 64'(edec_d) + rad_d;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      return -32'sh8000_0000;
    end else begin
      return 32'(v);
    end
  endfunction

  always_ff @(posedge clk) begin
    out_h_r <= sat32(sum_h);
    out_d_r <= sat32(sum_d);
  end

  assign out_valid         = vld_r[L_OUT-1];
  assign out_ha_error_out  = out_h_r;
  assign out_dec_error_out = out_d_r;

endmodule

`default_nettype wire

### dv/pointing_model_correction_test.sv
// Testbench of pointing_model_correction: random and directed correction requests
// are checked against a predictor that runs next to the block.
// Depends on pmc_pkg and the design files of the block.
`timescale 1ns / 1ps

module pointing_model_correction_test;

  localparam int AFB = 28;
  localparam int CFB = 16;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_RANDOM = 340;
  localparam logic [2:0] REG_LAST = 3'd7;
  localparam longint unsigned LIM56 = 64'd1 << 56;
  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
  localparam longint unsigned POLE_LIMIT = pmc_pkg::HALF_PI_Q62 >> (62 - AFB);

  typedef struct packed {
    logic signed [31:0] hour;
    logic signed [31:0] dec;
    logic signed [31:0] ha_err;
    logic signed [31:0] dec_err;
  } request_t;

  typedef struct packed {
    logic signed [31:0] ha_err;
    logic signed [31:0] dec_err;
  } correction_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_hour_angle = '0;
  logic signed [31:0] in_declination = '0;
  logic signed [31:0] in_ha_error_in = '0;
  logic signed [31:0] in_dec_error_in = '0;
  logic out_valid;
  logic signed [31:0] out_ha_error_out;
  logic signed [31:0] out_dec_error_out;

  logic [63:0] coef_pair [5];
  request_t pending_requests [$];
  correction_t expected_corrections [$];
  int n_errors = 0;
  int gap_left = 0;
  bit no_idle = 1'b0;
  bit took_request = 1'b0;

  pointing_model_correction dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .start(start), .busy(busy),
    .in_hour_angle(in_hour_angle), .in_declination(in_declination),
    .in_ha_error_in(in_ha_error_in), .in_dec_error_in(in_dec_error_in),
    .out_valid(out_valid), .out_ha_error_out(out_ha_error_out),
    .out_dec_error_out(out_dec_error_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] angle_phase(logic signed [31:0] a);
    logic [127:0] prod;
    longint unsigned m;
    logic [31:0] p;
    m = magnitude(longint'(a));
    prod = {64'd0, m} * {64'd0, pmc_pkg::PHASE_MUL_HI, pmc_pkg::PHASE_MUL_LO};
    p = prod[32 + AFB - 2 +: 32];
    return (a < 0) ? -p : p;
  endfunction

  function automatic void trig(input logic [31:0] p, output longint s, output longint c);
    longint unsigned r, x, x2, acc, sv, cv, sa, ca;
    logic [1:0] q;
    bit swap;
    q = p[31:30];
    r = p[29:0];
    swap = r > (pmc_pkg::ONE30 >> 1);
    if (swap) r = pmc_pkg::ONE30 - r;
    x = (r * pmc_pkg::HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    acc = pmc_pkg::ONE30;
    for (int i = 0; i < 5; i++)
      acc = pmc_pkg::ONE30 - ((x2 * acc) >> 30) / pmc_pkg::SIN_DIV[i];
    sv = (x * acc) >> 30;
    acc = pmc_pkg::ONE30;
    for (int i = 0; i < 6; i++)
      acc = pmc_pkg::ONE30 - ((x2 * acc) >> 30) / pmc_pkg::COS_DIV[i];
    cv = acc;
    sa = swap ? cv : sv;
    ca = swap ? sv : cv;
    case (q)
      2'd0: begin s = sa; c = ca; end
      2'd1: begin s = ca; c = -longint'(sa); end
      2'd2: begin s = -longint'(sa); c = -longint'(ca); end
      default: begin s = -longint'(ca); c = sa; end
    endcase
  endfunction

  // num * 2^sh / den toward zero, clamped to the working limit
  function automatic longint scaled_quotient(longint num, longint den, int sh);
    longint unsigned n, d, q, r, res;
    if (den == 0) return (num == 0) ? 0 : signed_of(LIM56, num < 0);
    n = magnitude(num);
    d = magnitude(den);
    q = n / d;
    r = n % d;
    if (q > (LIM56 >> sh)) res = LIM56;
    else res = (q << sh) + (r << sh) / d;
    if (res > LIM56) res = LIM56;
    return signed_of(res, (num < 0) != (den < 0));
  endfunction

  function automatic longint arcmin_radians(longint v);
    logic [127:0] prod;
    prod = {64'd0, magnitude(v)} * {77'd0, pmc_pkg::RAD_PER_ARCMIN};
    prod = prod >> (70 + CFB - AFB);
    return signed_of(prod[63:0], v < 0);
  endfunction

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] e, longint model);
    longint s;
    s = longint'(e) + model;
    if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
    if (s < -64'sh8000_0000) s = -64'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic correction_t predict_correction(request_t rq);
    longint a [5];
    longint b [5];
    longint sh, ch, sd, cd, junk, ch2, cd35, pol, hsum, hmod, dsum;
    logic [31:0] ph, pd;
    correction_t res;
    for (int i = 0; i < 5; i++) begin
      a[i] = longint'($signed(coef_pair[i][63:32]));
      b[i] = longint'($signed(coef_pair[i][31:0]));
    end
    ph = angle_phase(rq.hour);
    pd = angle_phase(rq.dec);
    trig(ph, sh, ch);
    trig(pd, sd, cd);
    trig(ph - pmc_pkg::PHASE_0P2, junk, ch2);
    trig(pd + pmc_pkg::PHASE_0P35, junk, cd35);
    pol = (a[0] * sh - a[1] * ch) >>> 22;
    hsum = ((pol * (sd >>> 8)) >>> 22) + a[2] * 256 + ((a[3] * ch2) >>> 22)
         + scaled_quotient(a[4] * sd, cd, 8);
    if (magnitude(longint'(rq.dec)) <= POLE_LIMIT) begin
      hmod = scaled_quotient(hsum, cd, 30);
    end else begin
      // past the pole: divide by 1e-6 instead of cos(dec)
      hmod = (magnitude(hsum) > LIM56 / 1000000) ? signed_of(LIM56, hsum < 0)
           : hsum * 1000000;
    end
    dsum = ((b[0] * ch) >>> 22) + ((b[1] * sh) >>> 22) + b[2] * 256
         + ((b[3] * cd35) >>> 22) + scaled_quotient(b[4] * sd, cd, 8);
    res.ha_err = sat_sum(rq.ha_err, arcmin_radians(hmod));
    res.dec_err = sat_sum(rq.dec_err, arcmin_radians(dsum));
    return res;
  endfunction

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 32'h3FFF_FFFF))) - 32'sh2000_0000;
      2: return $urandom_range(0, 1) ? 32'(POLE_LIMIT + $urandom_range(0, 8) - 4)
                                     : 32'(-POLE_LIMIT - $urandom_range(0, 8) + 4);
      3: return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
      default: return $signed(32'($urandom_range(0, 1 << 29))) - 32'sh1000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_error();
    return $urandom_range(0, 2) == 0 ? $urandom : $signed(32'($urandom_range(0, 1 << 24)))
                                                - 32'sh80_0000;
  endfunction

  // driver: one request at a time, random gaps, burst stretches with none
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !took_request)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        request_t rq;
        rq = pending_requests.pop_front();
        in_hour_angle <= rq.hour;
        in_declination <= rq.dec;
        in_ha_error_in <= rq.ha_err;
        in_dec_error_in <= rq.dec_err;
        start <= 1'b1;
        gap_left <= no_idle ? 0 : $urandom_range(0, 18);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: track config, predict accepted requests, check results
  always @(posedge clk) begin
    took_request <= rst_n && start && !busy;
    if (rst_n) begin
      if (cfg_we && cfg_index <= pmc_pkg::REG_TERM5) coef_pair[cfg_index] <= cfg_wdata;
      if (start && !busy) begin
        request_t rq;
        rq = '{in_hour_angle, in_declination, in_ha_error_in, in_dec_error_in};
        expected_corrections.push_back(predict_correction(rq));
      end
      if (out_valid) begin
        if (expected_corrections.size() == 0) begin
          $display("%0t: unexpected result ha=%0d dec=%0d", $realtime,
                   out_ha_error_out, out_dec_error_out);
          n_errors++;
        end else begin
          correction_t ex;
          ex = expected_corrections.pop_front();
          if (out_ha_error_out !== ex.ha_err) begin
            $display("%0t: ha_error_out expected %0d actual %0d", $realtime,
                     ex.ha_err, out_ha_error_out);
            n_errors++;
          end
          if (out_dec_error_out !== ex.dec_err) begin
            $display("%0t: dec_error_out expected %0d actual %0d", $realtime,
                     ex.dec_err, out_dec_error_out);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_request(logic signed [31:0] h, logic signed [31:0] d,
                               logic signed [31:0] he, logic signed [31:0] de);
    pending_requests.push_back('{h, d, he, de});
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || start || expected_corrections.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] plim;
    for (int i = 0; i < 5; i++) coef_pair[i] = '0;
    plim = 32'(POLE_LIMIT);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      // hold requests until the pipe is empty, then retune
      drain();
      for (int r = pmc_pkg::REG_TERM1; r <= pmc_pkg::REG_TERM5; r++) begin
        case (phase)
          0: write_reg(3'(r), {$signed(32'($urandom_range(0, 1 << 22))) - 32'sh20_0000,
                               $signed(32'($urandom_range(0, 1 << 22))) - 32'sh20_0000});
          1: write_reg(3'(r), {$urandom, $urandom});
          2: write_reg(3'(r), {32'h7FFF_FFFF, 32'h8000_0000});
          default: write_reg(3'(r), {32'h8000_0000, 32'h7FFF_FFFF});
        endcase
      end
      if (phase == 1) begin
        for (int r = pmc_pkg::REG_TERM5 + 1; r <= REG_LAST; r++)
          write_reg(3'(r), {$urandom, $urandom});
      end
      queue_request(0, 0, 0, 0);
      queue_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      queue_request(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
      queue_request(32'sh7FFF_FFFF, 0, -32'sh8000_0000, 32'sh7FFF_FFFF);
      for (int k = -2; k <= 2; k++) begin
        queue_request(32'sh1000_0000, plim + 32'(k), 0, 0);
        queue_request(-32'sh1000_0000, -plim + 32'(k), 32'sh7FFF_FFFF, -32'sh8000_0000);
      end
      queue_request(32'sh0000_0001, -32'sh0000_0001, 32'sh5555_5555, -32'sh5555_5556);
      queue_request(32'sh3243_F6A8, 32'sh1921_FB54, 0, 0);
      for (int n = 0; n < N_RANDOM; n++) begin
        if (n % 60 == 0) no_idle = $urandom_range(0, 2) == 0;
        queue_request(rand_angle(), rand_angle(), rand_error(), rand_error());
      end
    end
    drain();
    if (n_errors == 0) begin
      $display("pointing_model_correction_test passed");
    end else begin
      $display("pointing_model_correction_test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("pointing_model_correction_test failed");
    $finish;
  end

endmodule

### sim.f
design/pmc_pkg.sv
design/pmc_delay.sv
design/pmc_horner_cell.sv
design/pmc_sincos.sv
design/pmc_div_cell.sv
design/pmc_divider.sv
design/pmc_to_rad.sv
design/pointing_model_correction.sv
dv/pointing_model_correction_test.sv
